[rtl/core/mbe_pkg.sv]
package mbe_pkg;

    // Coordinate format: signed fixed point, FRAC_BITS fraction bits.
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 28;
    localparam int COUNT_BITS = 16;
    localparam int PIX_BITS   = 12;
    localparam int SIZE_BITS  = 13;

    // Derived widths.
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS     = 2 * COORD_BITS;
    localparam int SAT_BITS      = 2 * COORD_BITS;
    localparam int MAP_PROD_BITS = PIX_BITS + 1 + DIFF_BITS;
    localparam int DIV_CNT_BITS  = $clog2(COORD_BITS);
    localparam int CFG_IDX_BITS  = 3;

    // Escape bound 4.0 in the full-width product format.
    localparam logic [PROD_BITS-1:0] ESCAPE_LIMIT = PROD_BITS'(4) << (2 * FRAC_BITS);

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Register reset values.
    localparam logic signed [COORD_BITS-1:0] RESET_LEFT_EDGE  = COORD_BITS'(-536870912);
    localparam logic signed [COORD_BITS-1:0] RESET_UPPER_EDGE = COORD_BITS'(335544320);
    localparam logic signed [COORD_BITS-1:0] RESET_RIGHT_EDGE = COORD_BITS'(134217728);
    localparam logic signed [COORD_BITS-1:0] RESET_LOWER_EDGE = COORD_BITS'(-335544320);
    localparam logic [SIZE_BITS-1:0]  RESET_VIEW_WIDTH      = SIZE_BITS'(640);
    localparam logic [SIZE_BITS-1:0]  RESET_VIEW_HEIGHT     = SIZE_BITS'(480);
    localparam logic [COUNT_BITS-1:0] RESET_ITERATION_LIMIT = COUNT_BITS'(256);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LEFT_EDGE       = 3'd0,
        REG_UPPER_EDGE      = 3'd1,
        REG_RIGHT_EDGE      = 3'd2,
        REG_LOWER_EDGE      = 3'd3,
        REG_VIEW_WIDTH      = 3'd4,
        REG_VIEW_HEIGHT     = 3'd5,
        REG_ITERATION_LIMIT = 3'd6
    } cfg_reg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic div_start;
        logic map_mul;
        logic map_sum;
        logic iter_mul;
        logic iter_upd;
        logic out_load;
    } mbe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic stop;
    } mbe_status_t;

    // Clamp a wide signed value to the coordinate range.
    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [SAT_BITS-1:0] v
    );
        logic [SAT_BITS-COORD_BITS:0] top;
        logic signed [COORD_BITS-1:0] res;
        top = v[SAT_BITS-1:COORD_BITS-1];
        if ((&top) || !(|top)) begin
            res = v[COORD_BITS-1:0];
        end
        else if (v[SAT_BITS-1]) begin
            res = COORD_MIN;
        end
        else begin
            res = COORD_MAX;
        end
        return res;
    endfunction

endpackage

[rtl/core/mbe_div.sv]
module mbe_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mbe_pkg::COORD_BITS-1:0] dividend,
    input  logic [mbe_pkg::SIZE_BITS-1:0]  divisor,
    output logic                           busy,
    output logic [mbe_pkg::COORD_BITS-1:0] quotient
);
    import mbe_pkg::*;

    logic                    busy_reg, busy_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [SIZE_BITS-1:0]    rem_reg, rem_next;
    logic [SIZE_BITS-1:0]    dsr_reg, dsr_next;
    logic [COORD_BITS-1:0]   quo_reg, quo_next;
    logic [SIZE_BITS+1:0]    trial;

    // One restoring step per cycle, most significant quotient bit first.
    always_comb
    begin
        trial     = {1'b0, rem_reg, quo_reg[COORD_BITS-1]} - {2'b00, dsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_BITS'(COORD_BITS - 1);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (!trial[SIZE_BITS+1])
            begin
                rem_next = trial[SIZE_BITS-1:0];
                quo_next = {quo_reg[COORD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[SIZE_BITS-2:0], quo_reg[COORD_BITS-1]};
                quo_next = {quo_reg[COORD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/mbe_datapath.sv]
module mbe_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mbe_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [mbe_pkg::COORD_BITS-1:0]   cfg_data,
    input  logic [mbe_pkg::PIX_BITS-1:0]     pixel_x,
    input  logic [mbe_pkg::PIX_BITS-1:0]     pixel_y,
    input  mbe_pkg::mbe_cmd_t                cmd,
    output mbe_pkg::mbe_status_t             status,
    output logic [mbe_pkg::COUNT_BITS-1:0]   iteration_count
);
    import mbe_pkg::*;

    // Configuration registers.
    logic signed [COORD_BITS-1:0] left_reg, upper_reg, right_reg, lower_reg;
    logic [SIZE_BITS-1:0]         width_reg, height_reg;
    logic [COUNT_BITS-1:0]        limit_reg;

    // Per-transaction registers.
    logic [PIX_BITS-1:0]              px_reg, py_reg;
    logic signed [MAP_PROD_BITS-1:0]  prod_re_reg, prod_im_reg;
    logic signed [COORD_BITS-1:0]     cr_reg, ci_reg;
    logic signed [COORD_BITS-1:0]     x_reg, y_reg, x_next, y_next;
    logic signed [PROD_BITS-1:0]      xx_reg, yy_reg, xy_reg;
    logic [COUNT_BITS-1:0]            count_reg;
    logic [COUNT_BITS-1:0]            out_count_reg;

    // Step and mapping signals.
    logic signed [DIFF_BITS-1:0]  diff_re, diff_im, mag_re, mag_im;
    logic signed [DIFF_BITS-1:0]  step_re, step_im;
    logic [COORD_BITS-1:0]        quo_re, quo_im;
    logic                         busy_re, busy_im;
    logic signed [SAT_BITS-1:0]   sum_re, sum_im;

    // Iteration signals.
    logic signed [SAT_BITS-1:0]   dsq, nx_sum, ny_sum;
    logic [PROD_BITS-1:0]         mag;
    logic                         escape;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= RESET_LEFT_EDGE;
            upper_reg  <= RESET_UPPER_EDGE;
            right_reg  <= RESET_RIGHT_EDGE;
            lower_reg  <= RESET_LOWER_EDGE;
            width_reg  <= RESET_VIEW_WIDTH;
            height_reg <= RESET_VIEW_HEIGHT;
            limit_reg  <= RESET_ITERATION_LIMIT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LEFT_EDGE:       left_reg   <= cfg_data;
                REG_UPPER_EDGE:      upper_reg  <= cfg_data;
                REG_RIGHT_EDGE:      right_reg  <= cfg_data;
                REG_LOWER_EDGE:      lower_reg  <= cfg_data;
                REG_VIEW_WIDTH:      width_reg  <= cfg_data[SIZE_BITS-1:0];
                REG_VIEW_HEIGHT:     height_reg <= cfg_data[SIZE_BITS-1:0];
                REG_ITERATION_LIMIT: limit_reg  <= cfg_data[COUNT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Edge differences and their magnitudes for the step dividers.
    assign diff_re = DIFF_BITS'(right_reg) - DIFF_BITS'(left_reg);
    assign diff_im = DIFF_BITS'(lower_reg) - DIFF_BITS'(upper_reg);
    assign mag_re  = diff_re[DIFF_BITS-1] ? -diff_re : diff_re;
    assign mag_im  = diff_im[DIFF_BITS-1] ? -diff_im : diff_im;

    mbe_div u_div_re (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mag_re[COORD_BITS-1:0]),
        .divisor  (width_reg),
        .busy     (busy_re),
        .quotient (quo_re)
    );

    mbe_div u_div_im (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (mag_im[COORD_BITS-1:0]),
        .divisor  (height_reg),
        .busy     (busy_im),
        .quotient (quo_im)
    );

    // Signed step, truncated toward zero; a zero view size gives a zero step.
    always_comb
    begin
        if (width_reg == '0)
        begin
            step_re = '0;
        end
        else if (diff_re[DIFF_BITS-1])
        begin
            step_re = -$signed({1'b0, quo_re});
        end
        else
        begin
            step_re = $signed({1'b0, quo_re});
        end
        if (height_reg == '0)
        begin
            step_im = '0;
        end
        else if (diff_im[DIFF_BITS-1])
        begin
            step_im = -$signed({1'b0, quo_im});
        end
        else
        begin
            step_im = $signed({1'b0, quo_im});
        end
    end

    // Point mapping: edge plus pixel index times step, saturated.
    assign sum_re = SAT_BITS'(prod_re_reg) + SAT_BITS'(left_reg);
    assign sum_im = SAT_BITS'(prod_im_reg) + SAT_BITS'(upper_reg);

    // Escape test on the full-width squares of the current point.
    assign mag    = $unsigned(xx_reg) + $unsigned(yy_reg);
    assign escape = (mag >= ESCAPE_LIMIT);

    // Next point from the registered products.
    assign dsq    = xx_reg - yy_reg;
    assign nx_sum = (dsq >>> FRAC_BITS) + SAT_BITS'(cr_reg);
    assign ny_sum = (xy_reg >>> (FRAC_BITS - 1)) + SAT_BITS'(ci_reg);
    assign x_next = sat_coord(nx_sum);
    assign y_next = sat_coord(ny_sum);

    assign status.div_done = !busy_re && !busy_im;
    assign status.stop     = escape || (count_reg >= limit_reg);

    // Payload registers, loaded on command.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            px_reg <= pixel_x;
            py_reg <= pixel_y;
        end
        if (cmd.map_mul)
        begin
            prod_re_reg <= $signed({1'b0, px_reg}) * step_re;
            prod_im_reg <= $signed({1'b0, py_reg}) * step_im;
        end
        if (cmd.map_sum)
        begin
            cr_reg    <= sat_coord(sum_re);
            ci_reg    <= sat_coord(sum_im);
            x_reg     <= '0;
            y_reg     <= '0;
            count_reg <= '0;
        end
        if (cmd.iter_mul)
        begin
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            xy_reg <= x_reg * y_reg;
        end
        if (cmd.iter_upd)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            count_reg <= count_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            out_count_reg <= count_reg;
        end
    end

    assign iteration_count = out_count_reg;

endmodule

[rtl/core/mbe_ctrl.sv]
module mbe_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  mbe_pkg::mbe_status_t status,
    output mbe_pkg::mbe_cmd_t    cmd
);
    import mbe_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_MAP  = 7'b0000100,
        S_SUM  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_UPD  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Sequencing of one pixel through divide, map, iterate and output load.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                cmd.map_mul = 1'b1;
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                cmd.map_sum = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.iter_mul = 1'b1;
                state_next   = S_UPD;
            end
            S_UPD:
            begin
                if (status.stop)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.iter_upd = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output slot stays full until its transaction completes.
    assign out_valid_next = (out_valid_reg && out_stall) || cmd.out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/core/mandelbrot_escape_time.sv]
// Channel   Handshake              Payload
// config    cfg_write              cfg_index, cfg_data
// input     in_valid / in_stall    pixel_x, pixel_y
// output    out_valid / out_stall  iteration_count
//
// Two step dividers run in parallel for each pixel, and each iteration passes
// once through the product registers and back.
// Reset is asynchronous and active low; it loads the default view registers.
// The output register holds a finished result while the next pixel is taken;
// a result waits inside only when the previous one is still stalled.
module mandelbrot_escape_time (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [mbe_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [mbe_pkg::COORD_BITS-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [mbe_pkg::PIX_BITS-1:0]     pixel_x,
    input  logic [mbe_pkg::PIX_BITS-1:0]     pixel_y,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [mbe_pkg::COUNT_BITS-1:0]   iteration_count
);
    import mbe_pkg::*;

    mbe_cmd_t    cmd;
    mbe_status_t status;

    // Sequencer for one transaction at a time.
    mbe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Registers, dividers, multipliers and the output count.
    mbe_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .cmd             (cmd),
        .status          (status),
        .iteration_count (iteration_count)
    );

endmodule
